/* hw/rtl/scp_pkg.sv */
// Shared types, widths, codes and helpers for the convex polygon SAT collision block.
// Used by scp_norm, sat_convex_polygon_collision, both scp_checker files and the testbench; no dependencies.
`default_nettype none
package scp_pkg;

    localparam int MAX_CORNERS = 8;
    localparam int CNT_W       = $clog2(MAX_CORNERS + 1);
    localparam int IDX_W       = $clog2(MAX_CORNERS);
    localparam int CW          = 32;   // corner coordinate, Q16.16
    localparam int NW          = 16;   // normal component, Q1.15
    localparam int VW          = CW + 1;   // edge vector component
    localparam int PW          = CW + NW;  // one product
    localparam int DW          = PW + 2;   // projection and overlap
    localparam int PENW        = 31;
    localparam int TOLW        = 16;
    localparam int AW          = 4;

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [1:0] REG_SYM_A = 2'd0;
    localparam logic [1:0] REG_SYM_B = 2'd1;
    localparam logic [1:0] REG_TOL   = 2'd2;

    localparam logic [TOLW-1:0] TOL_RESET = 16'd655;

    typedef enum logic [2:0] {
        NRM_IDLE, NRM_SHIFT, NRM_SQX, NRM_SQY, NRM_ROOT, NRM_DIVLD, NRM_DIV, NRM_DONE
    } t_nrm_state;

    typedef enum logic [4:0] {
        SEQ_IDLE, SEQ_PASS, SEQ_EDGE, SEQ_EDGE2, SEQ_NWAIT, SEQ_PX, SEQ_PY, SEQ_PM,
        SEQ_CMP, SEQ_CX, SEQ_CY, SEQ_CM, SEQ_CMID, SEQ_SEL, SEQ_OX, SEQ_OY,
        SEQ_OFIN, SEQ_FIN
    } t_seq_state;

    typedef struct packed {
        logic                 start;
        logic signed [VW-1:0] vx;
        logic signed [VW-1:0] vy;
    } t_nrm_req;

    typedef struct packed {
        logic                 done;
        logic                 ok;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
    } t_nrm_res;

    function automatic logic signed [CW-1:0] sat32(input logic signed [CW+1:0] v);
        logic signed [CW+1:0] hi;
        logic signed [CW+1:0] lo;
        hi = {3'b000, {(CW-1){1'b1}}};
        lo = {3'b111, {(CW-1){1'b0}}};
        if (v > hi) begin
            return hi[CW-1:0];
        end else if (v < lo) begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/sat_convex_polygon_collision.sv */
// Top level of the convex polygon SAT collision block: corner stores, APB registers,
// sequencer and the shared 32x16 multiplier. Depends on scp_pkg and scp_norm.
//
//  channel   direction  handshake                 payload
//  in        sink       i_in_valid / o_in_stall   i_command, i_corner_x, i_corner_y
//  out       source     o_out_valid / i_out_stall o_hit, o_normal_*, o_penetration, o_contact_*
//  apb       sink       psel, penable, pready     paddr, pwdata, pwrite, prdata
//
// A compute holds the input stalled for its whole run: per tested edge scp_norm runs a
// shift search, 31 root steps and 2x16 divide steps, then every corner of both polygons
// is projected on the shared multiplier; each pass ends with a contact scan over its own
// corners, and the contact offset finishes the compute. The result waits in the output register while
// the output is stalled. Reset is synchronous and empties both polygons.
`default_nettype none
module sat_convex_polygon_collision (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [1:0]                     i_command,
    input  wire logic signed [scp_pkg::CW-1:0]  i_corner_x,
    input  wire logic signed [scp_pkg::CW-1:0]  i_corner_y,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_hit,
    output logic signed [scp_pkg::NW-1:0]       o_normal_x,
    output logic signed [scp_pkg::NW-1:0]       o_normal_y,
    output logic [scp_pkg::PENW-1:0]            o_penetration,
    output logic signed [scp_pkg::CW-1:0]       o_contact_x,
    output logic signed [scp_pkg::CW-1:0]       o_contact_y,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [scp_pkg::AW-1:0]         paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int CW = scp_pkg::CW;
    localparam int NW = scp_pkg::NW;
    localparam int DW = scp_pkg::DW;
    localparam int PW = scp_pkg::PW;
    localparam int CNT_W = scp_pkg::CNT_W;
    localparam int IDX_W = scp_pkg::IDX_W;

    scp_pkg::t_seq_state r_state, n_state;

    // configuration
    logic                     r_sym_a, r_sym_b;
    logic [scp_pkg::TOLW-1:0] r_tol;

    // corner stores
    logic signed [CW-1:0] r_ax [scp_pkg::MAX_CORNERS];
    logic signed [CW-1:0] r_ay [scp_pkg::MAX_CORNERS];
    logic signed [CW-1:0] r_bx [scp_pkg::MAX_CORNERS];
    logic signed [CW-1:0] r_by [scp_pkg::MAX_CORNERS];
    logic [CNT_W-1:0]     r_cnt_a, r_cnt_b;

    // sequencing
    logic             r_pass, r_side, r_first, r_have;
    logic [CNT_W-1:0] r_i, r_k, r_edges;
    logic [1:0]       r_found;

    // datapath
    logic signed [CW-1:0] r_pix, r_piy;
    logic signed [NW-1:0] r_nx, r_ny;
    logic signed [PW-1:0] r_prod;
    logic signed [DW-1:0] r_dot, r_tmin, r_tmax, r_omin, r_omax;
    logic signed [DW-1:0] r_best_ov, r_best_rel;
    logic signed [NW-1:0] r_best_nx, r_best_ny;
    logic signed [CW-1:0] r_c0x, r_c0y, r_c1x, r_c1y;
    logic signed [DW-1:0] r_a_ov;
    logic signed [NW-1:0] r_a_nx, r_a_ny;
    logic signed [CW-1:0] r_a_px, r_a_py, r_b_px, r_b_py;
    logic signed [NW-1:0] r_use_nx, r_use_ny, r_onx, r_ony;
    logic signed [CW-1:0] r_use_px, r_use_py, r_cx, r_cy;
    logic [scp_pkg::PENW-1:0] r_depth;
    logic                 r_res_hit;

    // output register
    logic                     r_out_valid, r_o_hit;
    logic signed [NW-1:0]     r_o_nx, r_o_ny;
    logic [scp_pkg::PENW-1:0] r_o_pen;
    logic signed [CW-1:0]     r_o_cx, r_o_cy;

    logic                 in_acc, cfg_wr, rd_b, out_free, from_b, sep, cand;
    logic [CNT_W-1:0]     np, nq, nside, j_full, j_idx, rd_sel;
    logic [IDX_W-1:0]     rd_idx;
    logic signed [CW-1:0] rd_x, rd_y, mul_a;
    logic signed [NW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [DW-1:0] dot_n, tl, ol, dd, dabs, tol_ext, sel_ov;
    logic [DW-18:0]       ov_sh;
    logic signed [CW:0]   mid_x, mid_y;
    scp_pkg::t_nrm_req    nrm_req;
    scp_pkg::t_nrm_res    nrm_res;

    scp_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (nrm_req),
        .o_res   (nrm_res)
    );

    assign o_in_stall = (r_state != scp_pkg::SEQ_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;

    always_comb begin
        case (paddr[3:2])
            scp_pkg::REG_SYM_A: prdata = {31'd0, r_sym_a};
            scp_pkg::REG_SYM_B: prdata = {31'd0, r_sym_b};
            scp_pkg::REG_TOL:   prdata = {16'd0, r_tol};
            default:            prdata = '0;
        endcase
    end

    assign np     = r_pass ? r_cnt_b : r_cnt_a;
    assign nq     = r_pass ? r_cnt_a : r_cnt_b;
    assign nside  = r_side ? nq : np;
    assign j_full = r_i + CNT_W'(1);
    assign j_idx  = (j_full == np) ? '0 : j_full;

    always_comb begin
        rd_sel = r_k;
        rd_b   = r_pass;
        case (r_state)
            scp_pkg::SEQ_EDGE:  rd_sel = r_i;
            scp_pkg::SEQ_EDGE2: rd_sel = j_idx;
            scp_pkg::SEQ_PX,
            scp_pkg::SEQ_PY:    rd_b = r_pass ^ r_side;
            default:            rd_sel = r_k;
        endcase
    end

    assign rd_idx = rd_sel[IDX_W-1:0];
    assign rd_x   = rd_b ? r_bx[rd_idx] : r_ax[rd_idx];
    assign rd_y   = rd_b ? r_by[rd_idx] : r_ay[rd_idx];

    // shared multiplier
    always_comb begin
        case (r_state)
            scp_pkg::SEQ_PY: begin mul_a = rd_y; mul_b = r_ny; end
            scp_pkg::SEQ_CX: begin mul_a = rd_x; mul_b = r_best_nx; end
            scp_pkg::SEQ_CY: begin mul_a = rd_y; mul_b = r_best_ny; end
            scp_pkg::SEQ_OX: begin mul_a = $signed({1'b0, r_depth}); mul_b = r_use_nx; end
            scp_pkg::SEQ_OY: begin mul_a = $signed({1'b0, r_depth}); mul_b = r_use_ny; end
            default:         begin mul_a = rd_x; mul_b = r_nx; end
        endcase
    end

    assign prod  = mul_a * mul_b;
    assign dot_n = DW'(r_prod) + DW'(prod);

    assign nrm_req.start = (r_state == scp_pkg::SEQ_EDGE2);
    assign nrm_req.vx    = scp_pkg::VW'(rd_y) - scp_pkg::VW'(r_piy);
    assign nrm_req.vy    = scp_pkg::VW'(r_pix) - scp_pkg::VW'(rd_x);

    assign sep     = (r_tmax < r_omin) || (r_omax < r_tmin);
    assign tl      = r_tmax - r_omin;
    assign ol      = r_omax - r_tmin;
    assign dd      = r_dot - r_best_rel;
    assign dabs    = dd[DW-1] ? -dd : dd;
    assign tol_ext = $signed(DW'({r_tol, 15'd0}));
    assign cand    = dabs < tol_ext;
    assign mid_x   = (CW+1)'(r_c0x) + (CW+1)'(r_c1x);
    assign mid_y   = (CW+1)'(r_c0y) + (CW+1)'(r_c1y);
    assign from_b  = r_a_ov > r_best_ov;
    assign sel_ov  = from_b ? r_best_ov : r_a_ov;
    assign ov_sh   = sel_ov[DW-2:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scp_pkg::SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            scp_pkg::SEQ_IDLE: begin
                if (in_acc && i_command == scp_pkg::CMD_COMPUTE) n_state = scp_pkg::SEQ_PASS;
            end
            scp_pkg::SEQ_PASS: begin
                n_state = (np == '0 || nq == '0) ? scp_pkg::SEQ_FIN : scp_pkg::SEQ_EDGE;
            end
            scp_pkg::SEQ_EDGE: begin
                if (r_i == r_edges) begin
                    n_state = r_have ? scp_pkg::SEQ_CX : scp_pkg::SEQ_FIN;
                end else begin
                    n_state = scp_pkg::SEQ_EDGE2;
                end
            end
            scp_pkg::SEQ_EDGE2: n_state = scp_pkg::SEQ_NWAIT;
            scp_pkg::SEQ_NWAIT: begin
                if (nrm_res.done) n_state = nrm_res.ok ? scp_pkg::SEQ_PX : scp_pkg::SEQ_EDGE;
            end
            scp_pkg::SEQ_PX: n_state = scp_pkg::SEQ_PY;
            scp_pkg::SEQ_PY: n_state = scp_pkg::SEQ_PM;
            scp_pkg::SEQ_PM: begin
                if (r_k + CNT_W'(1) == nside && r_side) begin
                    n_state = scp_pkg::SEQ_CMP;
                end else begin
                    n_state = scp_pkg::SEQ_PX;
                end
            end
            scp_pkg::SEQ_CMP: n_state = sep ? scp_pkg::SEQ_FIN : scp_pkg::SEQ_EDGE;
            scp_pkg::SEQ_CX:  n_state = scp_pkg::SEQ_CY;
            scp_pkg::SEQ_CY:  n_state = scp_pkg::SEQ_CM;
            scp_pkg::SEQ_CM: begin
                n_state = (r_k + CNT_W'(1) == np) ? scp_pkg::SEQ_CMID : scp_pkg::SEQ_CX;
            end
            scp_pkg::SEQ_CMID: n_state = r_pass ? scp_pkg::SEQ_SEL : scp_pkg::SEQ_PASS;
            scp_pkg::SEQ_SEL:  n_state = scp_pkg::SEQ_OX;
            scp_pkg::SEQ_OX:   n_state = scp_pkg::SEQ_OY;
            scp_pkg::SEQ_OY:   n_state = scp_pkg::SEQ_OFIN;
            scp_pkg::SEQ_OFIN: n_state = scp_pkg::SEQ_FIN;
            scp_pkg::SEQ_FIN:  if (out_free) n_state = scp_pkg::SEQ_IDLE;
            default:           n_state = scp_pkg::SEQ_IDLE;
        endcase
    end

    // corner stores, no reset: entries beyond the counts are never read
    always_ff @(posedge i_clk) begin
        if (in_acc && i_command == scp_pkg::CMD_LOAD_A
            && r_cnt_a < CNT_W'(scp_pkg::MAX_CORNERS)) begin
            r_ax[r_cnt_a[IDX_W-1:0]] <= i_corner_x;
            r_ay[r_cnt_a[IDX_W-1:0]] <= i_corner_y;
        end
        if (in_acc && i_command == scp_pkg::CMD_LOAD_B
            && r_cnt_b < CNT_W'(scp_pkg::MAX_CORNERS)) begin
            r_bx[r_cnt_b[IDX_W-1:0]] <= i_corner_x;
            r_by[r_cnt_b[IDX_W-1:0]] <= i_corner_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_a     <= 1'b1;
            r_sym_b     <= 1'b1;
            r_tol       <= scp_pkg::TOL_RESET;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_out_valid <= 1'b0;
            r_pass      <= 1'b0;
            r_side      <= 1'b0;
            r_first     <= 1'b0;
            r_have      <= 1'b0;
            r_i         <= '0;
            r_k         <= '0;
            r_edges     <= '0;
            r_found     <= '0;
            r_res_hit   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    scp_pkg::REG_SYM_A: r_sym_a <= pwdata[0];
                    scp_pkg::REG_SYM_B: r_sym_b <= pwdata[0];
                    scp_pkg::REG_TOL:   r_tol   <= pwdata[scp_pkg::TOLW-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                scp_pkg::SEQ_IDLE: begin
                    if (in_acc && i_command == scp_pkg::CMD_LOAD_A
                        && r_cnt_a < CNT_W'(scp_pkg::MAX_CORNERS)) begin
                        r_cnt_a <= r_cnt_a + CNT_W'(1);
                    end
                    if (in_acc && i_command == scp_pkg::CMD_LOAD_B
                        && r_cnt_b < CNT_W'(scp_pkg::MAX_CORNERS)) begin
                        r_cnt_b <= r_cnt_b + CNT_W'(1);
                    end
                    if (in_acc && i_command == scp_pkg::CMD_COMPUTE) begin
                        r_pass    <= 1'b0;
                        r_res_hit <= 1'b0;
                    end
                end
                scp_pkg::SEQ_PASS: begin
                    r_i     <= '0;
                    r_have  <= 1'b0;
                    r_edges <= (r_pass ? r_sym_b : r_sym_a) ? (np >> 1) : np;
                end
                scp_pkg::SEQ_EDGE: begin
                    if (r_i == r_edges) begin
                        r_k     <= '0;
                        r_found <= '0;
                        r_c0x   <= '0;
                        r_c0y   <= '0;
                    end else begin
                        r_pix <= rd_x;
                        r_piy <= rd_y;
                    end
                end
                scp_pkg::SEQ_NWAIT: begin
                    if (nrm_res.done) begin
                        if (nrm_res.ok) begin
                            r_nx    <= nrm_res.nx;
                            r_ny    <= nrm_res.ny;
                            r_k     <= '0;
                            r_side  <= 1'b0;
                            r_first <= 1'b1;
                        end else begin
                            // zero-length edge: skip it
                            r_i <= r_i + CNT_W'(1);
                        end
                    end
                end
                scp_pkg::SEQ_PX: r_prod <= prod;
                scp_pkg::SEQ_PY: r_dot  <= dot_n;
                scp_pkg::SEQ_PM: begin
                    if (!r_side) begin
                        if (r_first || r_dot < r_tmin) r_tmin <= r_dot;
                        if (r_first || r_dot > r_tmax) r_tmax <= r_dot;
                    end else begin
                        if (r_first || r_dot < r_omin) r_omin <= r_dot;
                        if (r_first || r_dot > r_omax) r_omax <= r_dot;
                    end
                    r_first <= 1'b0;
                    r_k     <= r_k + CNT_W'(1);
                    if (r_k + CNT_W'(1) == nside && !r_side) begin
                        r_side  <= 1'b1;
                        r_k     <= '0;
                        r_first <= 1'b1;
                    end
                end
                scp_pkg::SEQ_CMP: begin
                    if (!sep) begin
                        r_i <= r_i + CNT_W'(1);
                        if (tl < ol) begin
                            if (!r_have || tl < r_best_ov) begin
                                r_best_ov  <= tl;
                                r_best_rel <= r_tmax;
                                r_best_nx  <= r_nx;
                                r_best_ny  <= r_ny;
                                r_have     <= 1'b1;
                            end
                        end else begin
                            if (!r_have || ol < r_best_ov) begin
                                r_best_ov  <= ol;
                                r_best_rel <= -r_tmin;
                                r_best_nx  <= -r_nx;
                                r_best_ny  <= -r_ny;
                                r_have     <= 1'b1;
                            end
                        end
                    end
                end
                scp_pkg::SEQ_CX: r_prod <= prod;
                scp_pkg::SEQ_CY: r_dot  <= dot_n;
                scp_pkg::SEQ_CM: begin
                    if (cand) begin
                        if (r_found == 2'd0) begin
                            r_c0x <= rd_x;
                            r_c0y <= rd_y;
                        end else if (r_found == 2'd1) begin
                            r_c1x <= rd_x;
                            r_c1y <= rd_y;
                        end
                        if (r_found != 2'd3) r_found <= r_found + 2'd1;
                    end
                    r_k <= r_k + CNT_W'(1);
                end
                scp_pkg::SEQ_CMID: begin
                    if (!r_pass) begin
                        r_a_ov <= r_best_ov;
                        r_a_nx <= r_best_nx;
                        r_a_ny <= r_best_ny;
                        r_a_px <= (r_found == 2'd2) ? mid_x[CW:1] : r_c0x;
                        r_a_py <= (r_found == 2'd2) ? mid_y[CW:1] : r_c0y;
                        r_pass <= 1'b1;
                    end else begin
                        r_b_px <= (r_found == 2'd2) ? mid_x[CW:1] : r_c0x;
                        r_b_py <= (r_found == 2'd2) ? mid_y[CW:1] : r_c0y;
                    end
                end
                scp_pkg::SEQ_SEL: begin
                    // tie stays with A
                    r_use_nx <= from_b ? r_best_nx : r_a_nx;
                    r_use_ny <= from_b ? r_best_ny : r_a_ny;
                    r_use_px <= from_b ? r_b_px : r_a_px;
                    r_use_py <= from_b ? r_b_py : r_a_py;
                    r_onx    <= from_b ? -r_best_nx : r_a_nx;
                    r_ony    <= from_b ? -r_best_ny : r_a_ny;
                    r_depth  <= (ov_sh[DW-18:scp_pkg::PENW] != '0) ? '1
                                : ov_sh[scp_pkg::PENW-1:0];
                    r_res_hit <= 1'b1;
                end
                scp_pkg::SEQ_OX: r_prod <= prod;
                scp_pkg::SEQ_OY: begin
                    r_cx   <= scp_pkg::sat32((CW+2)'(r_use_px) + (CW+2)'(r_prod >>> 15));
                    r_prod <= prod;
                end
                scp_pkg::SEQ_OFIN: begin
                    r_cy <= scp_pkg::sat32((CW+2)'(r_use_py) + (CW+2)'(r_prod >>> 15));
                end
                scp_pkg::SEQ_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_hit     <= r_res_hit;
                        r_o_nx      <= r_res_hit ? r_onx : '0;
                        r_o_ny      <= r_res_hit ? r_ony : '0;
                        r_o_pen     <= r_res_hit ? r_depth : '0;
                        r_o_cx      <= r_res_hit ? r_cx : '0;
                        r_o_cy      <= r_res_hit ? r_cy : '0;
                        r_cnt_a     <= '0;
                        r_cnt_b     <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_o_hit;
    assign o_normal_x    = r_o_nx;
    assign o_normal_y    = r_o_ny;
    assign o_penetration = r_o_pen;
    assign o_contact_x   = r_o_cx;
    assign o_contact_y   = r_o_cy;

endmodule
`default_nettype wire

/* hw/rtl/scp_norm.sv */
// Iterative unit normaliser: shift search, square sum, digit-by-digit root, two divides.
// Depends on scp_pkg for widths, state enum and request/result structs.
`default_nettype none
module scp_norm (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire scp_pkg::t_nrm_req i_req,
    output scp_pkg::t_nrm_res      o_res
);

    scp_pkg::t_nrm_state r_state, n_state;

    logic [scp_pkg::VW-1:0] r_ax, r_ay;
    logic                   r_negx, r_negy;
    logic [59:0]            r_sq;
    logic [61:0]            r_s;
    logic [34:0]            r_rem;
    logic [30:0]            r_root;
    logic [45:0]            r_num, r_den;
    logic [15:0]            r_q;
    logic [4:0]             r_cnt;
    logic                   r_ydiv, r_ok;
    logic signed [scp_pkg::NW-1:0] r_nx, r_ny;

    logic [scp_pkg::VW-1:0] m, in_ax, in_ay;
    logic [34:0]            rem_n, trial;
    logic [15:0]            q_n;
    logic [14:0]            q_cap;
    logic [29:0]            div_src;

    assign in_ax = i_req.vx[scp_pkg::VW-1] ? scp_pkg::VW'(-i_req.vx) : scp_pkg::VW'(i_req.vx);
    assign in_ay = i_req.vy[scp_pkg::VW-1] ? scp_pkg::VW'(-i_req.vy) : scp_pkg::VW'(i_req.vy);
    assign m     = (r_ax > r_ay) ? r_ax : r_ay;
    assign rem_n = {r_rem[32:0], r_s[61:60]};
    assign trial = {2'b00, r_root, 2'b01};
    assign q_n   = {r_q[14:0], (r_num >= r_den)};
    assign q_cap = q_n[15] ? 15'h7FFF : q_n[14:0];
    assign div_src = r_ydiv ? r_ay[29:0] : r_ax[29:0];

    assign o_res.done = (r_state == scp_pkg::NRM_DONE);
    assign o_res.ok   = r_ok;
    assign o_res.nx   = r_nx;
    assign o_res.ny   = r_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scp_pkg::NRM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            scp_pkg::NRM_IDLE: begin
                if (i_req.start) begin
                    n_state = (in_ax == '0 && in_ay == '0) ? scp_pkg::NRM_DONE
                                                           : scp_pkg::NRM_SHIFT;
                end
            end
            scp_pkg::NRM_SHIFT: begin
                if (m < scp_pkg::VW'(1 << 30) && m >= scp_pkg::VW'(1 << 29)) begin
                    n_state = scp_pkg::NRM_SQX;
                end
            end
            scp_pkg::NRM_SQX:   n_state = scp_pkg::NRM_SQY;
            scp_pkg::NRM_SQY:   n_state = scp_pkg::NRM_ROOT;
            scp_pkg::NRM_ROOT:  if (r_cnt == '0) n_state = scp_pkg::NRM_DIVLD;
            scp_pkg::NRM_DIVLD: n_state = scp_pkg::NRM_DIV;
            scp_pkg::NRM_DIV: begin
                if (r_cnt == '0) begin
                    n_state = r_ydiv ? scp_pkg::NRM_DONE : scp_pkg::NRM_DIVLD;
                end
            end
            scp_pkg::NRM_DONE:  n_state = scp_pkg::NRM_IDLE;
            default:            n_state = scp_pkg::NRM_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok   <= 1'b0;
            r_ydiv <= 1'b0;
            r_cnt  <= '0;
        end else begin
            case (r_state)
                scp_pkg::NRM_IDLE: begin
                    if (i_req.start) begin
                        r_ax   <= in_ax;
                        r_ay   <= in_ay;
                        r_negx <= i_req.vx[scp_pkg::VW-1];
                        r_negy <= i_req.vy[scp_pkg::VW-1];
                        r_ok   <= 1'b0;
                        r_ydiv <= 1'b0;
                    end
                end
                scp_pkg::NRM_SHIFT: begin
                    // bring the larger magnitude into [2^29, 2^30)
                    if (m >= scp_pkg::VW'(1 << 30)) begin
                        r_ax <= r_ax >> 1;
                        r_ay <= r_ay >> 1;
                    end else if (m < scp_pkg::VW'(1 << 29)) begin
                        r_ax <= r_ax << 1;
                        r_ay <= r_ay << 1;
                    end
                end
                scp_pkg::NRM_SQX: begin
                    r_sq <= r_ax[29:0] * r_ax[29:0];
                end
                scp_pkg::NRM_SQY: begin
                    r_s    <= 62'(r_sq) + 62'(r_ay[29:0] * r_ay[29:0]);
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= 5'd30;
                end
                scp_pkg::NRM_ROOT: begin
                    if (rem_n >= trial) begin
                        r_rem  <= rem_n - trial;
                        r_root <= {r_root[29:0], 1'b1};
                    end else begin
                        r_rem  <= rem_n;
                        r_root <= {r_root[29:0], 1'b0};
                    end
                    r_s   <= r_s << 2;
                    r_cnt <= r_cnt - 5'd1;
                end
                scp_pkg::NRM_DIVLD: begin
                    // round half up: add half the divisor
                    r_num <= {1'b0, div_src, 15'd0} + 46'(r_root[30:1]);
                    r_den <= {r_root, 15'd0};
                    r_q   <= '0;
                    r_cnt <= 5'd15;
                end
                scp_pkg::NRM_DIV: begin
                    if (r_num >= r_den) begin
                        r_num <= r_num - r_den;
                    end
                    r_q   <= q_n;
                    r_den <= r_den >> 1;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        if (r_ydiv) begin
                            r_ny <= r_negy ? -$signed({1'b0, q_cap}) : $signed({1'b0, q_cap});
                            r_ok <= 1'b1;
                        end else begin
                            r_nx <= r_negx ? -$signed({1'b0, q_cap}) : $signed({1'b0, q_cap});
                            r_ydiv <= 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/scp_checker.sv */
// Port-level checks for sat_convex_polygon_collision, bound to the top level.
// Depends on scp_pkg for widths and command codes.
`default_nettype none
module scp_assert (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic [1:0]                    i_command,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic                          o_hit,
    input wire logic signed [scp_pkg::NW-1:0] o_normal_x,
    input wire logic signed [scp_pkg::NW-1:0] o_normal_y,
    input wire logic [scp_pkg::PENW-1:0]      o_penetration,
    input wire logic signed [scp_pkg::CW-1:0] o_contact_x,
    input wire logic signed [scp_pkg::CW-1:0] o_contact_y
);

    // held item stays valid and keeps its contact x, normal x and penetration
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_contact_x)
        && $stable(o_normal_x) && $stable(o_penetration))
        else $error("output item changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_normal_x == '0 && o_normal_y == '0
        && o_penetration == '0 && o_contact_x == '0 && o_contact_y == '0)
        else $error("miss item carries non-zero fields");

    a_hit_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> (o_normal_x != '0 || o_normal_y != '0))
        else $error("hit item with zero normal");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_command == scp_pkg::CMD_COMPUTE |=> o_in_stall)
        else $error("input taken right after a compute item");

endmodule

bind sat_convex_polygon_collision scp_assert u_scp_assert (.*);
`default_nettype wire

/* dv/scp_checker.sv */
// Scoreboard for the convex polygon SAT collision block: tracks APB writes and accepted items,
// predicts each collision result and compares it with the output channel. Depends on scp_pkg.
`timescale 1ns / 100ps
module scp_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_stall,
    input  wire logic [1:0]                    i_command,
    input  wire logic signed [scp_pkg::CW-1:0] i_corner_x,
    input  wire logic signed [scp_pkg::CW-1:0] i_corner_y,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic                          i_hit,
    input  wire logic signed [scp_pkg::NW-1:0] i_normal_x,
    input  wire logic signed [scp_pkg::NW-1:0] i_normal_y,
    input  wire logic [scp_pkg::PENW-1:0]      i_penetration,
    input  wire logic signed [scp_pkg::CW-1:0] i_contact_x,
    input  wire logic signed [scp_pkg::CW-1:0] i_contact_y,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [scp_pkg::AW-1:0]        paddr,
    input  wire logic [31:0]                   pwdata,
    input  wire logic                          pready,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import scp_pkg::*;

    typedef struct {
        longint overlap;
        longint nx;
        longint ny;
        longint px;
        longint py;
    } axis_t;

    typedef struct packed {
        logic                   hit;
        logic signed [NW-1:0]   nx;
        logic signed [NW-1:0]   ny;
        logic [PENW-1:0]        pen;
        logic signed [CW-1:0]   cx;
        logic signed [CW-1:0]   cy;
    } collision_t;

    longint         poly_x [2][MAX_CORNERS];
    longint         poly_y [2][MAX_CORNERS];
    int             poly_n [2];
    bit             sym_a, sym_b;
    logic [TOLW-1:0] tolerance;
    collision_t     expected_hits [$];
    int             fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_hits.size();

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit unit_normal(longint vx, longint vy, output longint nx,
                                       output longint ny);
        longint unsigned ax, ay, m, l, rx, ry;
        nx = 0;
        ny = 0;
        ax = vx < 0 ? -vx : vx;
        ay = vy < 0 ? -vy : vy;
        m  = ax > ay ? ax : ay;
        if (m == 0) return 0;
        while (m >= (64'd1 << 30)) begin
            ax >>= 1; ay >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            ax <<= 1; ay <<= 1; m <<= 1;
        end
        l  = int_sqrt(ax * ax + ay * ay);
        rx = (ax * 32768 + l / 2) / l;
        ry = (ay * 32768 + l / 2) / l;
        if (rx > 32767) rx = 32767;
        if (ry > 32767) ry = 32767;
        nx = vx < 0 ? -longint'(rx) : longint'(rx);
        ny = vy < 0 ? -longint'(ry) : longint'(ry);
        return 1;
    endfunction

    // One-way pass over the edge normals of polygon s against the other polygon
    function automatic bit axis_pass(int s, bit sym, output axis_t r);
        int     np, nq, edges, found, i, j, k;
        bit     have;
        longint best, tol, c0x, c0y, c1x, c1y, nx, ny;
        longint tmin, tmax, omin, omax, tl, ol, c, rel, v, d, sx, sy;
        r     = '{0, 0, 0, 0, 0};
        np    = poly_n[s];
        nq    = poly_n[1-s];
        edges = sym ? np / 2 : np;
        have  = 0;
        best  = 0;
        found = 0;
        tol   = longint'(tolerance) << 15;
        c0x = 0; c0y = 0; c1x = 0; c1y = 0;
        if (np == 0 || nq == 0) return 0;
        for (i = 0; i < edges; i++) begin
            j = (i + 1) % np;
            if (!unit_normal(poly_y[s][j] - poly_y[s][i], poly_x[s][i] - poly_x[s][j], nx, ny))
                continue;
            tmin = poly_x[s][0] * nx + poly_y[s][0] * ny;
            tmax = tmin;
            for (k = 1; k < np; k++) begin
                v = poly_x[s][k] * nx + poly_y[s][k] * ny;
                if (v < tmin) tmin = v;
                if (v > tmax) tmax = v;
            end
            omin = poly_x[1-s][0] * nx + poly_y[1-s][0] * ny;
            omax = omin;
            for (k = 1; k < nq; k++) begin
                v = poly_x[1-s][k] * nx + poly_y[1-s][k] * ny;
                if (v < omin) omin = v;
                if (v > omax) omax = v;
            end
            if (tmax < omin || omax < tmin) return 0;
            tl = tmax - omin;
            ol = omax - tmin;
            if (tl < ol) begin
                c = tl; rel = tmax;
            end else begin
                c = ol; rel = -tmin; nx = -nx; ny = -ny;
            end
            if (!have || c < r.overlap) begin
                have = 1;
                r.overlap = c; r.nx = nx; r.ny = ny; best = rel;
            end
        end
        if (!have) return 0;
        for (k = 0; k < np; k++) begin
            d = poly_x[s][k] * r.nx + poly_y[s][k] * r.ny - best;
            if (d < 0) d = -d;
            if (d < tol) begin
                if (found == 0) begin
                    c0x = poly_x[s][k]; c0y = poly_y[s][k];
                end else if (found == 1) begin
                    c1x = poly_x[s][k]; c1y = poly_y[s][k];
                end
                found++;
            end
        end
        if (found == 2) begin
            sx = c0x + c1x;
            sy = c0y + c1y;
            r.px = sx >>> 1;
            r.py = sy >>> 1;
        end else begin
            r.px = c0x;
            r.py = c0y;
        end
        return 1;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic collision_t predict_collision();
        axis_t           ra, rb, u;
        bit              from_b;
        longint unsigned ov;
        longint          depth, nx, ny;
        collision_t      res;
        res = '0;
        if (axis_pass(0, sym_a, ra) && axis_pass(1, sym_b, rb)) begin
            from_b = ra.overlap > rb.overlap;
            u      = from_b ? rb : ra;
            ov     = longint'(u.overlap) >> 16;
            if (ov > 64'h7FFF_FFFF) ov = 64'h7FFF_FFFF;
            depth  = longint'(ov);
            nx     = from_b ? -u.nx : u.nx;
            ny     = from_b ? -u.ny : u.ny;
            res.hit = 1'b1;
            res.nx  = nx[NW-1:0];
            res.ny  = ny[NW-1:0];
            res.pen = ov[PENW-1:0];
            // offset uses the pass's own normal, floored
            res.cx  = clamp32(u.px + ((u.nx * depth) >>> 15));
            res.cy  = clamp32(u.py + ((u.ny * depth) >>> 15));
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        collision_t got, want;
        if (!i_rst_n) begin
            poly_n[0] = 0;
            poly_n[1] = 0;
            sym_a     = 1;
            sym_b     = 1;
            tolerance = TOL_RESET;
            expected_hits.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_SYM_A: sym_a     = pwdata[0];
                    REG_SYM_B: sym_b     = pwdata[0];
                    REG_TOL:   tolerance = pwdata[TOLW-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_command)
                    CMD_LOAD_A, CMD_LOAD_B: begin
                        if (poly_n[i_command[0]] < MAX_CORNERS) begin
                            poly_x[i_command[0]][poly_n[i_command[0]]] = longint'(i_corner_x);
                            poly_y[i_command[0]][poly_n[i_command[0]]] = longint'(i_corner_y);
                            poly_n[i_command[0]]++;
                        end
                    end
                    CMD_COMPUTE: begin
                        expected_hits.push_back(predict_collision());
                        poly_n[0] = 0;
                        poly_n[1] = 0;
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_hit, i_normal_x, i_normal_y, i_penetration, i_contact_x, i_contact_y};
                if (expected_hits.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: unexpected result hit=%0b", $realtime, i_hit);
                    fails++;
                end else begin
                    want = expected_hits.pop_front();
                    if (got != want) begin
                        if (fails < 10)
                            $display({"%0t: mismatch exp hit=%0b n=(%0d,%0d) pen=%0d c=(%0d,%0d)",
                                      " got hit=%0b n=(%0d,%0d) pen=%0d c=(%0d,%0d)"},
                                     $realtime, want.hit, want.nx, want.ny, want.pen,
                                     want.cx, want.cy, got.hit, got.nx, got.ny, got.pen,
                                     got.cx, got.cy);
                        fails++;
                    end
                end
            end
        end
    end

    initial fails = 0;

endmodule

/* dv/tb_sat_convex_polygon_collision.sv */
// Testbench top for sat_convex_polygon_collision: clock, reset, corner and compute stimulus,
// APB register phases and output stalls. Depends on scp_pkg, the block and scp_checker.
`timescale 1ns / 100ps
module tb_sat_convex_polygon_collision;
    import scp_pkg::*;

    localparam longint CYCLE_LIMIT = 3_000_000;
    localparam real    PI          = 3.14159265358979;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 in_valid = 0;
    logic                 in_stall;
    logic [1:0]           command = CMD_LOAD_A;
    logic signed [CW-1:0] corner_x = '0;
    logic signed [CW-1:0] corner_y = '0;
    logic                 out_valid;
    logic                 out_stall = 0;
    logic                 hit;
    logic signed [NW-1:0] normal_x, normal_y;
    logic [PENW-1:0]      penetration;
    logic signed [CW-1:0] contact_x, contact_y;
    logic                 psel = 0, penable = 0, pwrite = 0;
    logic [AW-1:0]        paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    int                   fail_count, pending;
    int                   items_sent = 0;
    bit                   no_gaps = 0;
    int                   stall_left = 0;
    longint               cycles = 0;

    always #2 i_clk = ~i_clk;

    sat_convex_polygon_collision u_top (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_command(command), .i_corner_x(corner_x), .i_corner_y(corner_y),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_hit(hit), .o_normal_x(normal_x), .o_normal_y(normal_y),
        .o_penetration(penetration), .o_contact_x(contact_x), .o_contact_y(contact_y),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    scp_checker u_scoreboard (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_command(command), .i_corner_x(corner_x), .i_corner_y(corner_y),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_hit(hit), .i_normal_x(normal_x), .i_normal_y(normal_y),
        .i_penetration(penetration), .i_contact_x(contact_x), .i_contact_y(contact_y),
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output stalls: mostly short, a few long, none in gap-free phases
    always @(posedge i_clk) begin
        int r;
        cycles <= cycles + 1;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (no_gaps) begin
            out_stall <= 0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                out_stall <= 0;
            end else if (r < 95) begin
                out_stall  <= 1;
                stall_left <= $urandom_range(0, 2);
            end else begin
                out_stall  <= 1;
                stall_left <= $urandom_range(20, 60);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] cmd, logic signed [CW-1:0] x, logic signed [CW-1:0] y);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1;
        command  <= cmd;
        corner_x <= x;
        corner_y <= y;
        do @(posedge i_clk); while (in_stall);
        items_sent++;
    endtask

    // hold the sender until every result is back, then let stray work settle
    task automatic drain();
        in_valid <= 0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= AW'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    task automatic set_regs(bit sa, bit sb, logic [15:0] tol);
        reg_write(REG_SYM_A, {31'd0, sa});
        reg_write(REG_SYM_B, {31'd0, sb});
        reg_write(REG_TOL, {16'd0, tol});
    endtask

    function automatic logic signed [CW-1:0] clip(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[CW-1:0];
    endfunction

    task automatic load_shape(logic [1:0] cmd, int k, longint cx, longint cy, longint rad);
        real ph, ang;
        int  i;
        ph = $urandom_range(0, 359) * PI / 180.0;
        for (i = 0; i < k; i++) begin
            ang = 2.0 * PI * i / k + ph;
            send_item(cmd, clip(cx + longint'($rtoi(rad * $cos(ang)))),
                      clip(cy + longint'($rtoi(rad * $sin(ang)))));
        end
    endtask

    task automatic random_group();
        int     ka, kb, n, i, r;
        longint cx, cy, ra, rb, ox, oy;
        if ($urandom_range(0, 99) < 82) begin
            ka = $urandom_range(0, 9) == 0 ? $urandom_range(7, 8) : $urandom_range(3, 5);
            kb = $urandom_range(0, 9) == 0 ? $urandom_range(7, 8) : $urandom_range(3, 5);
            if ($urandom_range(0, 9) == 0) begin
                cx = 0; cy = 0;
                ra = $urandom_range(1 << 28, 1 << 30);
                rb = $urandom_range(1 << 28, 1 << 30);
            end else begin
                cx = longint'($urandom_range(0, 1 << 27)) - (1 << 26);
                cy = longint'($urandom_range(0, 1 << 27)) - (1 << 26);
                ra = $urandom_range(1 << 16, 1 << 24);
                rb = $urandom_range(1 << 16, 1 << 24);
            end
            ox = longint'($urandom_range(0, 2 * (ra + rb))) - (ra + rb);
            oy = longint'($urandom_range(0, 2 * (ra + rb))) - (ra + rb);
            if ($urandom_range(0, 2) == 0) begin
                load_shape(CMD_LOAD_B, kb, cx + ox, cy + oy, rb);
                load_shape(CMD_LOAD_A, ka, cx, cy, ra);
            end else begin
                load_shape(CMD_LOAD_A, ka, cx, cy, ra);
                load_shape(CMD_LOAD_B, kb, cx + ox, cy + oy, rb);
            end
            send_item(CMD_COMPUTE, $urandom, $urandom);
        end else begin
            // noise: raw corners, overfull stores, ignored commands
            n = $urandom_range(0, 20);
            for (i = 0; i < n; i++) begin
                r = $urandom_range(0, 9);
                send_item(r < 5 ? CMD_LOAD_A : (r < 9 ? CMD_LOAD_B : 2'd3), $urandom, $urandom);
            end
            if ($urandom_range(0, 4) != 0) send_item(CMD_COMPUTE, $urandom, $urandom);
        end
    endtask

    initial begin
        int          ph, target;
        bit          sa [5] = '{0, 0, 1, 0, 1};
        bit          sb [5] = '{0, 1, 0, 0, 1};
        logic [15:0] tl [5];
        tl = '{16'd655, 16'd0, 16'hFFFF, 16'd0, 16'd1};
        tl[3] = $urandom;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        set_regs(0, 0, 16'd655);
        send_item(CMD_COMPUTE, 0, 0);
        send_item(CMD_LOAD_A, 0, 0);
        send_item(CMD_LOAD_A, 32'sh0002_0000, 0);
        send_item(CMD_LOAD_A, 32'sh0002_0000, 32'sh0002_0000);
        send_item(CMD_LOAD_A, 0, 32'sh0002_0000);
        send_item(CMD_LOAD_B, 32'sh0001_0000, 32'sh0001_0000);
        send_item(CMD_LOAD_B, 32'sh0003_0000, 32'sh0001_0000);
        send_item(CMD_LOAD_B, 32'sh0003_0000, 32'sh0003_0000);
        send_item(CMD_LOAD_B, 32'sh0001_0000, 32'sh0003_0000);
        send_item(CMD_COMPUTE, 0, 0);
        send_item(CMD_LOAD_A, 32'sh8000_0000, 32'sh8000_0000);
        send_item(CMD_LOAD_A, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(CMD_LOAD_A, 0, 32'sh7FFF_FFFF);
        send_item(CMD_LOAD_B, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(CMD_LOAD_B, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(CMD_LOAD_B, 0, 32'sh8000_0000);
        send_item(CMD_COMPUTE, 0, 0);
        // duplicated corner gives a zero-length edge; B with one corner has only a zero-length edge
        send_item(CMD_LOAD_A, 0, 0);
        send_item(CMD_LOAD_A, 0, 0);
        send_item(CMD_LOAD_A, 32'sh0001_0000, 0);
        send_item(CMD_LOAD_A, 0, 32'sh0001_0000);
        send_item(CMD_LOAD_B, 32'sh0000_4000, 32'sh0000_4000);
        send_item(2'd3, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(CMD_COMPUTE, 0, 0);
        drain();

        for (ph = 0; ph < 5; ph++) begin
            set_regs(sa[ph], sb[ph], tl[ph]);
            no_gaps = (ph == 2);
            target  = items_sent + 265;
            while (items_sent < target) begin
                random_group();
                if ($urandom_range(0, 29) == 0) drain();
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/scp_pkg.sv
hw/rtl/scp_norm.sv
hw/rtl/sat_convex_polygon_collision.sv
hw/rtl/scp_checker.sv
dv/scp_checker.sv
dv/tb_sat_convex_polygon_collision.sv
